// File: rtl/core/lhts_pkg.sv
// shared types, constants and register map of the hop table shuffle block
package lhts_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int FREQ_MIN_MHZ = 902;
  localparam int FREQ_MAX_MHZ = 928;

  localparam int IDX_W   = $clog2(MAX_CHANNELS);
  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 7;
  localparam int LFSR_W  = 16;
  localparam int DCNT_W  = $clog2(LFSR_W);
  localparam int PADDR_W = 5;

  localparam logic [LFSR_W-1:0] BAND_SUM = LFSR_W'(FREQ_MIN_MHZ) + LFSR_W'(FREQ_MAX_MHZ);

  localparam logic OP_REBUILD = 1'b0;
  localparam logic OP_READ    = 1'b1;

  typedef enum logic [2:0] {
    REG_AIR_SPEED     = 3'd0,
    REG_NET_ID        = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_HOP_ENABLE    = 3'd3,
    REG_MAX_DWELL_MS  = 3'd4,
    REG_BANDWIDTH_KHZ = 3'd5,
    REG_SPREAD_FACTOR = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] air_speed;
    logic [7:0]  net_id;
    logic [6:0]  channel_count;
    logic        hop_enable;
    logic [15:0] max_dwell_ms;
    logic [8:0]  bandwidth_khz;
    logic [3:0]  spread_factor;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_RDQ,
    ST_SWJ,
    ST_SWI,
    ST_RCAP,
    ST_RBCAP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic seed_load;
    logic lfsr_step;
    logic div_step;
    logic swap_j;
    logic swap_i;
    logic cap_read;
    logic cap_rebuild;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic n_small;
    logic last_swap;
    logic out_free;
  } status_t;

endpackage

// File: rtl/core/lhts_if.sv
// valid/ready channel interfaces for request and result beats
interface lhts_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [5:0] entry_index;

  modport source (output valid, output op, output entry_index, input ready);
  modport sink (input valid, input op, input entry_index, output ready);
endinterface

interface lhts_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] channel_slot;
  logic       index_error;
  logic       rebuilt;

  modport source (output valid, output channel_slot, output index_error, output rebuilt,
                  input ready);
  modport sink (input valid, input channel_slot, input index_error, input rebuilt,
                output ready);
endinterface

// File: rtl/core/lhts_ram.sv
// generic ram, one write port and two registered read ports
module lhts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/core/lhts_ctrl.sv
// controller state machine: request decode, shuffle walk sequencing, result hand-off
module lhts_ctrl import lhts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_op,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_op == OP_READ) begin
            state_next = ST_RCAP;
          end else begin
            cmd.seed_load = 1'b1;
            state_next    = status.n_small ? ST_RBCAP : ST_STEP;
          end
        end
      end
      ST_STEP: begin
        cmd.lfsr_step = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_RDQ;
        end
      end
      // table reads of i and j are in flight
      ST_RDQ: begin
        state_next = ST_SWJ;
      end
      ST_SWJ: begin
        cmd.swap_j = 1'b1;
        state_next = ST_SWI;
      end
      ST_SWI: begin
        cmd.swap_i = 1'b1;
        state_next = status.last_swap ? ST_RBCAP : ST_STEP;
      end
      ST_RCAP: begin
        cmd.cap_read = 1'b1;
        state_next   = ST_FIN;
      end
      ST_RBCAP: begin
        cmd.cap_rebuild = 1'b1;
        state_next      = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/lhts_dp.sv
// datapath: lfsr, serial remainder unit, hop table with valid bits, result registers
module lhts_dp import lhts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [SLOT_W-1:0] out_channel_slot,
  output logic              out_index_error,
  output logic              out_rebuilt
);

  logic [CNT_W-1:0]  n;
  logic [LFSR_W-1:0] seed;
  logic [LFSR_W-1:0] lfsr, lfsr_next;
  logic [LFSR_W-1:0] dvd;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W-1:0]  rem_next;
  logic [DCNT_W-1:0] dcnt;
  logic [IDX_W-1:0]  i_idx;
  logic [IDX_W-1:0]  j_idx;
  logic [IDX_W-1:0]  idx_q;

  logic [MAX_CHANNELS-1:0] vld;
  logic [IDX_W-1:0]  raddr_a, raddr_b;
  logic [IDX_W-1:0]  addr_a_q, addr_b_q;
  logic              vld_a_q, vld_b_q;
  logic [SLOT_W-1:0] rdata_a, rdata_b;
  logic [SLOT_W-1:0] val_a, val_b;
  logic [SLOT_W-1:0] tj_q;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [SLOT_W-1:0] wdata;
  logic              rd_err;

  logic [SLOT_W-1:0] res_slot;
  logic              res_err;
  logic              res_rebuilt;

  assign n = (cfg.channel_count > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
                                                         : cfg.channel_count;

  assign seed = cfg.air_speed + LFSR_W'(cfg.net_id) + BAND_SUM
              + LFSR_W'(cfg.channel_count) + LFSR_W'(cfg.hop_enable) + cfg.max_dwell_ms
              + LFSR_W'(cfg.bandwidth_khz) + LFSR_W'(cfg.spread_factor);

  assign lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};

  // restoring remainder, one dividend bit per cycle
  assign rem_sh   = {rem, dvd[LFSR_W-1]};
  assign rem_next = (rem_sh >= {1'b0, n}) ? CNT_W'(rem_sh - {1'b0, n}) : CNT_W'(rem_sh);
  assign j_idx    = rem[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= '0;
    end else if (cmd.seed_load) begin
      lfsr <= seed;
    end else if (cmd.lfsr_step) begin
      lfsr <= lfsr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lfsr_step) begin
      dvd  <= lfsr_next;
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dvd  <= {dvd[LFSR_W-2:0], 1'b0};
      rem  <= rem_next;
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.seed_load) begin
      i_idx <= '0;
    end else if (cmd.swap_i) begin
      i_idx <= i_idx + 1'b1;
    end
    if (cmd.accept) begin
      idx_q <= in_entry_index;
    end
  end

  // an entry without its valid bit holds its own position
  assign raddr_a = cmd.accept ? in_entry_index : i_idx;
  assign raddr_b = j_idx;

  always_ff @(posedge clk) begin
    addr_a_q <= raddr_a;
    addr_b_q <= raddr_b;
    vld_a_q  <= vld[raddr_a];
    vld_b_q  <= vld[raddr_b];
  end

  assign val_a = vld_a_q ? rdata_a : SLOT_W'(addr_a_q);
  assign val_b = vld_b_q ? rdata_b : SLOT_W'(addr_b_q);

  assign we    = cmd.swap_j | cmd.swap_i;
  assign waddr = cmd.swap_j ? j_idx : i_idx;
  assign wdata = cmd.swap_j ? val_a : tj_q;

  always_ff @(posedge clk) begin
    if (cmd.swap_j) begin
      tj_q <= val_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.seed_load) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        if (CNT_W'(k) < n) begin
          vld[k] <= 1'b0;
        end
      end
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  lhts_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(MAX_CHANNELS)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign rd_err = ({1'b0, idx_q} >= n);

  always_ff @(posedge clk) begin
    if (cmd.cap_read) begin
      res_slot    <= rd_err ? '0 : val_a;
      res_err     <= rd_err;
      res_rebuilt <= 1'b0;
    end else if (cmd.cap_rebuild) begin
      res_slot    <= '0;
      res_err     <= 1'b0;
      res_rebuilt <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel_slot <= res_slot;
      out_index_error  <= res_err;
      out_rebuilt      <= res_rebuilt;
    end
  end

  assign status.div_done  = (dcnt == DCNT_W'(LFSR_W - 1));
  assign status.n_small   = (n <= CNT_W'(1));
  assign status.last_swap = ((CNT_W'(i_idx) + CNT_W'(2)) >= n);
  assign status.out_free  = ~out_valid | out_ready;

endmodule

// File: rtl/core/lfsr_hop_table_shuffle.sv
// top level: configuration registers, controller and datapath of the hop table shuffle
//
// Request beats arrive on in_ch: op 0 rebuilds the hop table from the link
// registers, op 1 reads the slot stored at entry_index. Every request gives
// exactly one result beat on out_ch, in request order.
// Link registers are written over the apb-style port (byte address 4*i) and
// must only change while no request is in flight.
// A read goes from acceptance through result capture and the hand-off state to
// a valid result beat; the next request is taken in the cycle after the result
// is registered, so a read is not taken before the last one is through.
// A rebuild walks n-1 swaps, n being the channel count capped at 64 (none if
// n <= 1); each swap is one lfsr step, all 16 dividend bits through the bit-serial
// remainder unit, one table read and two table writes on the single write port.
// Reset puts the registers at their defaults, the lfsr at zero and the table
// in identity order at once through per-entry valid bits; no clearing pass.
// When the receiver stalls the result waits in the output register; one more
// request may be accepted and finished, then the block holds in_ch.ready low.
module lfsr_hop_table_shuffle import lhts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  lhts_in_if.sink            in_ch,
  lhts_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t     cfg;
  cmd_t     cmd;
  status_t  status;
  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.air_speed     <= 16'd4800;
      cfg.net_id        <= 8'd192;
      cfg.channel_count <= 7'd50;
      cfg.hop_enable    <= 1'b1;
      cfg.max_dwell_ms  <= 16'd400;
      cfg.bandwidth_khz <= 9'd500;
      cfg.spread_factor <= 4'd9;
    end else if (wr_en) begin
      case (reg_idx)
        REG_AIR_SPEED:     cfg.air_speed     <= pwdata[15:0];
        REG_NET_ID:        cfg.net_id        <= pwdata[7:0];
        REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[6:0];
        REG_HOP_ENABLE:    cfg.hop_enable    <= pwdata[0];
        REG_MAX_DWELL_MS:  cfg.max_dwell_ms  <= pwdata[15:0];
        REG_BANDWIDTH_KHZ: cfg.bandwidth_khz <= pwdata[8:0];
        REG_SPREAD_FACTOR: cfg.spread_factor <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_AIR_SPEED:     prdata = {16'd0, cfg.air_speed};
      REG_NET_ID:        prdata = {24'd0, cfg.net_id};
      REG_CHANNEL_COUNT: prdata = {25'd0, cfg.channel_count};
      REG_HOP_ENABLE:    prdata = {31'd0, cfg.hop_enable};
      REG_MAX_DWELL_MS:  prdata = {16'd0, cfg.max_dwell_ms};
      REG_BANDWIDTH_KHZ: prdata = {23'd0, cfg.bandwidth_khz};
      REG_SPREAD_FACTOR: prdata = {28'd0, cfg.spread_factor};
      default:           prdata = '0;
    endcase
  end

  lhts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lhts_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .in_entry_index   (in_ch.entry_index),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_channel_slot (out_ch.channel_slot),
    .out_index_error  (out_ch.index_error),
    .out_rebuilt      (out_ch.rebuilt)
  );

endmodule
